### rtl/core/hbp_pkg.sv
`default_nettype none

package hbp_pkg;

    // Field widths of the stream payloads
    localparam int ACTION_W    = 2;
    localparam int SYMBOL_W    = 8;
    localparam int CODE_W      = 16;
    localparam int LEN_W       = 5;
    localparam int BYTE_W      = 8;
    localparam int VBITS_W     = 4;
    localparam int FILL_W      = 3;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 16;

    // Longest code word the table keeps; longer loads saturate to it
    localparam int MAX_CODE_LEN = 16;

    // Window that holds pending bits plus one full code word
    localparam int WIN_W = BYTE_W + CODE_W;

    // Input request kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FLUSH  = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic wr;         // write one table entry
        logic rd;         // start a table lookup
        logic flush;      // move the partial byte into the emit window
        logic merge;      // merge looked-up code into the accumulator
        logic emit;       // load the output register
        logic emit_idx;   // which byte of the window to emit
        logic emit_last;  // last byte caused by this request
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       sym_ok;     // symbol lies inside the table
        logic       fill_nz;    // accumulator holds pending bits
        logic       out_free;   // output register can take a byte
        logic [1:0] merge_cnt;  // full bytes the current merge yields
        logic [1:0] cnt;        // bytes in the window from the last merge or flush
    } t_sts;

endpackage

`default_nettype wire

### rtl/core/hbp_dpath.sv
`default_nettype none

module hbp_dpath #(
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [hbp_pkg::SYMBOL_W-1:0]  i_symbol,
    input  wire logic [hbp_pkg::CODE_W-1:0]    i_code_word,
    input  wire logic [hbp_pkg::LEN_W-1:0]     i_code_len,
    input  wire hbp_pkg::t_cmd                 i_cmd,
    output hbp_pkg::t_sts                      o_sts,
    input  wire logic                          i_m_tready,
    output logic                               o_m_valid,
    output logic [hbp_pkg::BYTE_W-1:0]         o_packed_byte,
    output logic [hbp_pkg::VBITS_W-1:0]        o_valid_bits,
    output logic                               o_last_of_run
);
    import hbp_pkg::*;

    localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

    // Code and length tables; lengths carry a valid bit per entry
    logic [CODE_W-1:0]       r_code_mem [SYMBOL_COUNT];
    logic [LEN_W-1:0]        r_len_mem  [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] r_len_vld;

    logic [CODE_W-1:0] r_code_rd;
    logic [LEN_W-1:0]  r_len_rd;
    logic              r_vld_rd;

    // Bit accumulator and emit window
    logic [BYTE_W-1:0]   r_acc, n_acc;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [2*BYTE_W-1:0] r_win;
    logic [1:0]          r_cnt;
    logic [VBITS_W-1:0]  r_wbits;

    // Output register
    logic               r_ovalid;
    logic [BYTE_W-1:0]  r_obyte;
    logic [VBITS_W-1:0] r_obits;
    logic               r_olast;

    logic [IDX_W-1:0]  idx;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  len_eff;
    logic [CODE_W-1:0] code_m;
    logic [LEN_W-1:0]  total;
    logic [WIN_W-1:0]  win;

    assign idx = i_symbol[IDX_W-1:0];

    // Clip load lengths to the longest code supported
    assign len_sat = (i_code_len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : i_code_len;

    // Write tables on load, read with registered data on lookup
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_code_mem[idx] <= i_code_word;
            r_len_mem[idx]  <= len_sat;
        end
        if (i_cmd.rd) begin
            r_code_rd <= r_code_mem[idx];
            r_len_rd  <= r_len_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld <= '0;
            r_vld_rd  <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_len_vld[idx] <= 1'b1;
            end
            if (i_cmd.rd) begin
                r_vld_rd <= r_len_vld[idx];
            end
        end
    end

    // Merge the code into the pending bits, MSB first from bit 7
    always_comb begin
        len_eff = r_vld_rd ? r_len_rd : '0;
        code_m  = r_code_rd & CODE_W'((17'h1 << len_eff) - 17'h1);
        total   = LEN_W'(r_fill) + len_eff;
        win     = {r_acc, {CODE_W{1'b0}}}
                | (WIN_W'(code_m) << (LEN_W'(WIN_W) - total));
        n_acc   = r_acc;
        n_fill  = r_fill;
        if (i_cmd.merge) begin
            n_fill = total[FILL_W-1:0];
            case (total[4:3])
                2'd0:    n_acc = win[23:16];
                2'd1:    n_acc = win[15:8];
                default: n_acc = win[7:0];
            endcase
        end else if (i_cmd.flush) begin
            n_acc  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            r_acc  <= n_acc;
            r_fill <= n_fill;
            if (i_cmd.merge) begin
                r_cnt <= total[4:3];
            end else if (i_cmd.flush) begin
                r_cnt <= 2'd1;
            end
        end
    end

    // Capture full bytes or the partial byte for the emit sequence
    always_ff @(posedge i_clk) begin
        if (i_cmd.merge) begin
            r_win   <= win[WIN_W-1:BYTE_W];
            r_wbits <= VBITS_W'(BYTE_W);
        end else if (i_cmd.flush) begin
            r_win   <= {r_acc, {BYTE_W{1'b0}}};
            r_wbits <= VBITS_W'(r_fill);
        end
    end

    // Output register: load on emit, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_obyte <= i_cmd.emit_idx ? r_win[7:0] : r_win[15:8];
            r_obits <= r_wbits;
            r_olast <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_sts.sym_ok    = ({1'b0, i_symbol} < 9'(SYMBOL_COUNT));
        o_sts.fill_nz   = (r_fill != '0);
        o_sts.out_free  = !r_ovalid || i_m_tready;
        o_sts.merge_cnt = total[4:3];
        o_sts.cnt       = r_cnt;
    end

    assign o_m_valid     = r_ovalid;
    assign o_packed_byte = r_obyte;
    assign o_valid_bits  = r_obits;
    assign o_last_of_run = r_olast;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> o_sts.out_free)
        else $error("byte emitted while output register busy");

    a_rd_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd |=> i_cmd.merge)
        else $error("table lookup not followed by merge");

    a_flush_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_fill == '0) && (r_acc == '0) && (r_cnt == 2'd1))
        else $error("flush did not empty the accumulator");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.wr, i_cmd.rd, i_cmd.flush, i_cmd.merge, i_cmd.emit}))
        else $error("more than one datapath command at once");

endmodule

`default_nettype wire

### rtl/core/hbp_ctrl.sv
`default_nettype none

module hbp_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_valid,
    input  wire hbp_pkg::t_action i_action,
    output logic                  o_s_ready,
    input  wire hbp_pkg::t_sts    i_sts,
    output hbp_pkg::t_cmd         o_cmd
);
    import hbp_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_idx, n_idx;
    logic   take;

    assign o_s_ready = (r_state == S_IDLE);
    assign take      = i_s_valid && o_s_ready;

    // Decode requests and sequence lookup, merge and byte emission
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (take) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            o_cmd.wr = i_sts.sym_ok;
                        end
                        ACT_ENCODE: begin
                            if (i_sts.sym_ok) begin
                                o_cmd.rd = 1'b1;
                                n_state  = S_LOOK;
                            end
                        end
                        ACT_FLUSH: begin
                            if (i_sts.fill_nz) begin
                                o_cmd.flush = 1'b1;
                                n_idx       = 1'b0;
                                n_state     = S_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LOOK: begin
                o_cmd.merge = 1'b1;
                n_idx       = 1'b0;
                n_state     = (i_sts.merge_cnt == 2'd0) ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_idx  = r_idx;
                    o_cmd.emit_last = r_idx || (i_sts.cnt == 2'd1);
                    if (o_cmd.emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and byte index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    a_look_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |=> (r_state != S_LOOK))
        else $error("merge state held for more than one cycle");

    a_emit_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (i_sts.cnt == 2'd1 || i_sts.cnt == 2'd2))
        else $error("emit sequence with no bytes in window");

    a_second_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_idx) |-> (i_sts.cnt == 2'd2))
        else $error("second byte emitted from a one-byte window");

endmodule

`default_nettype wire

### rtl/core/huffman_bit_packer.sv
`default_nettype none

// Table-driven Huffman encoder with an MSB-first byte packer. Each input
// request on the slave stream is a table load, a symbol encode or a flush.
// A load writes one code word and length (clipped to 16). An encode does a
// registered table read, then a merge into the bit accumulator, and then
// emits each full byte it produces, zero to two; a flush moves the partial
// byte into the emit window and then emits it. The byte sequencer in the
// controller handles one request at a time and takes no new request until
// the last one is through; byte emission waits while the master side
// stalls. Bytes leave through an output register, and flushed bytes
// carry their count of valid bits. Length entries come out of reset as
// zero through per-entry valid bits, so no clearing pass is needed.
module huffman_bit_packer #(
    parameter int SYMBOL_COUNT = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // action[1:0], symbol[9:2], code_word[25:10], code_len[30:26], zero[31]
    input  wire logic [31:0] i_s_axis_tdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // packed_byte[7:0], valid_bits[11:8], zero[15:12]
    output logic [15:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready
);
    import hbp_pkg::*;

    t_action            action;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_word;
    logic [LEN_W-1:0]    code_len;
    t_cmd               cmd;
    t_sts               sts;
    logic [BYTE_W-1:0]  packed_byte;
    logic [VBITS_W-1:0] valid_bits;

    // Unpack the request fields
    assign action    = t_action'(i_s_axis_tdata[1:0]);
    assign symbol    = i_s_axis_tdata[9:2];
    assign code_word = i_s_axis_tdata[25:10];
    assign code_len  = i_s_axis_tdata[30:26];

    hbp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_action  (action),
        .o_s_ready (o_s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    hbp_dpath #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_symbol      (symbol),
        .i_code_word   (code_word),
        .i_code_len    (code_len),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_m_tready    (i_m_axis_tready),
        .o_m_valid     (o_m_axis_tvalid),
        .o_packed_byte (packed_byte),
        .o_valid_bits  (valid_bits),
        .o_last_of_run (o_m_axis_tlast)
    );

    // Pack the result fields
    assign o_m_axis_tdata = {4'b0000, valid_bits, packed_byte};

endmodule

`default_nettype wire
